// ----- src/urbc_pkg.sv -----
// Shared types and constants for the UART ring buffer channel unit.
package urbc_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ErrW      = 4;
  localparam int unsigned BurstLenW = 10;

  // Request action codes. Codes five to seven change nothing.
  typedef enum logic [ActionW-1:0] {
    ACT_LINE       = 3'd0,
    ACT_READ       = 3'd1,
    ACT_WRITE      = 3'd2,
    ACT_TAKE_ERR   = 3'd3,
    ACT_IDLE_QUERY = 3'd4
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0]   action;
    logic                 rx_ready;
    logic [ErrW-1:0]      line_errors;
    logic                 tx_empty;
    logic                 tx_complete;
    logic [ByteW-1:0]     data_byte;
    logic [BurstLenW-1:0] burst_len;
    logic                 burst_last;
  } req_t;

  typedef struct packed {
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic             accepted;
    logic             error_taken;
    logic             idle;
    logic             tx_irq_enable;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_byte;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
    logic need_read;
  } dp_status_t;

endpackage

// ----- src/urbc_req_if.sv -----
// Request channel interface: handshake plus one request's fields.
interface urbc_req_if import urbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic                 rx_ready;
  logic [ErrW-1:0]      line_errors;
  logic                 tx_empty;
  logic                 tx_complete;
  logic [ByteW-1:0]     data_byte;
  logic [BurstLenW-1:0] burst_len;
  logic                 burst_last;

  modport source (
    output valid, action, rx_ready, line_errors, tx_empty, tx_complete,
           data_byte, burst_len, burst_last,
    input  ready
  );
  modport sink (
    input  valid, action, rx_ready, line_errors, tx_empty, tx_complete,
           data_byte, burst_len, burst_last,
    output ready
  );
endinterface

// ----- src/urbc_rsp_if.sv -----
// Response channel interface: handshake plus one result's fields.
interface urbc_rsp_if import urbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             rx_valid;
  logic [ByteW-1:0] rx_byte;
  logic             tx_valid;
  logic [ByteW-1:0] tx_byte;
  logic             accepted;
  logic             error_taken;
  logic             idle;
  logic             tx_irq_enable;

  modport source (
    output valid, rx_valid, rx_byte, tx_valid, tx_byte, accepted, error_taken,
           idle, tx_irq_enable,
    input  ready
  );
  modport sink (
    input  valid, rx_valid, rx_byte, tx_valid, tx_byte, accepted, error_taken,
           idle, tx_irq_enable,
    output ready
  );
endinterface

// ----- src/uart_ring_buffer_channel_unit.sv -----
// Top level of the UART ring buffer channel unit: controller, datapath and channel ports.
//
//   Channel  Direction  Handshake            Carries
//   req_i    in         req_i.valid/ready    action, line status, host byte, burst info
//   rsp_o    out        rsp_o.valid/ready    popped/sent bytes, flags, transmit enable
//
// Steps: each request is captured and then executed. A request that reads a ring (host
// read of a nonempty receive ring, or a line event that hands out a transmit byte) then
// also waits for the registered read of the ring RAM before its result is complete.
// Reset clears the pointers, the burst state, the error flag and the enable; the
// ring RAMs are not cleared, since only bytes written earlier are ever read back.
// A new request is accepted while the previous result still waits in the output
// register; execution of it waits until that register is free.
module uart_ring_buffer_channel_unit import urbc_pkg::*; #(
  parameter int unsigned DEPTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urbc_req_if.sink   req_i,
  urbc_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  req_t       req;
  rsp_t       rsp;
  logic       req_ready;
  logic       rsp_valid;

  // Gather the request fields into one word for the capture register.
  assign req.action      = req_i.action;
  assign req.rx_ready    = req_i.rx_ready;
  assign req.line_errors = req_i.line_errors;
  assign req.tx_empty    = req_i.tx_empty;
  assign req.tx_complete = req_i.tx_complete;
  assign req.data_byte   = req_i.data_byte;
  assign req.burst_len   = req_i.burst_len;
  assign req.burst_last  = req_i.burst_last;
  assign req_i.ready     = req_ready;

  // The controller only sequences; all decisions on the rings are made in the datapath.
  urbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  urbc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // The result register drives the response channel directly.
  assign rsp_o.valid         = rsp_valid;
  assign rsp_o.rx_valid      = rsp.rx_valid;
  assign rsp_o.rx_byte       = rsp.rx_byte;
  assign rsp_o.tx_valid      = rsp.tx_valid;
  assign rsp_o.tx_byte       = rsp.tx_byte;
  assign rsp_o.accepted      = rsp.accepted;
  assign rsp_o.error_taken   = rsp.error_taken;
  assign rsp_o.idle          = rsp.idle;
  assign rsp_o.tx_irq_enable = rsp.tx_irq_enable;

endmodule

// ----- src/urbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module urbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/urbc_ctrl.sv -----
// Controller state machine: sequences capture, execution and the RAM read.
module urbc_ctrl import urbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold the request until the output register can take a result.
        if (!status_i.out_busy) begin
          cmd_o.execute = 1'b1;
          state_d       = status_i.need_read ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.load_byte = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/urbc_datapath.sv -----
// Datapath: ring pointers, burst tracking, flags, both rings and the result register.
module urbc_datapath import urbc_pkg::*; #(
  parameter int unsigned DEPTH = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  req_t       req_i,
  input  logic       rsp_ready_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  localparam int unsigned PW = $clog2(2 * DEPTH);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned BW = (CW > BurstLenW) ? CW : BurstLenW;
  localparam logic [PW:0]   TwoDepth = (PW + 1)'(2 * DEPTH);
  localparam logic [PW-1:0] PtrDepth = PW'(DEPTH);
  localparam logic [PW-1:0] PtrLast  = PW'(2 * DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                            input logic [CW-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + (PW + 1)'(n);
    if (s >= TwoDepth) begin
      s = s - TwoDepth;
    end
    ptr_add = PW'(s);
  endfunction

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    slot = (p >= PtrDepth) ? AW'(p - PtrDepth) : AW'(p);
  endfunction

  function automatic logic [PW-1:0] ring_fill(input logic [PW-1:0] h,
                                              input logic [PW-1:0] t);
    logic [PW:0] f;
    if (h >= t) begin
      f = {1'b0, h} - {1'b0, t};
    end else begin
      f = {1'b0, h} + TwoDepth - {1'b0, t};
    end
    ring_fill = PW'(f);
  endfunction

  // Captured request.
  req_t req_q;

  // Control state.
  logic [PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [CW-1:0] burst_off_q, burst_off_d;
  logic          burst_rej_q, burst_rej_d;
  logic          err_q, err_d;
  logic          tx_en_q, tx_en_d;
  logic          rsp_valid_q;

  // Result register.
  rsp_t rsp_q, res;

  // Decisions for the current request.
  logic          rx_push, rx_pop, tx_pop, tx_wr;
  logic          rx_full, rx_empty, tx_ring_empty;
  logic [CW-1:0] tx_free, off_new;
  logic          opening, rej_now;
  logic [AW-1:0] tx_waddr;

  logic [ByteW-1:0] rx_rdata, tx_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    rx_full       = ring_fill(rx_head_q, rx_tail_q) >= PtrDepth;
    rx_empty      = (rx_head_q == rx_tail_q);
    tx_ring_empty = (tx_head_q == tx_tail_q);
    tx_free       = CW'(PtrDepth - ring_fill(tx_head_q, tx_tail_q));
    tx_waddr      = slot(ptr_add(tx_head_q, burst_off_q));
    opening       = (burst_off_q == '0) && !burst_rej_q;
    rej_now       = burst_rej_q;
    off_new       = burst_off_q;

    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    burst_off_d = burst_off_q;
    burst_rej_d = burst_rej_q;
    err_d       = err_q;
    tx_en_d     = tx_en_q;
    rx_push     = 1'b0;
    rx_pop      = 1'b0;
    tx_pop      = 1'b0;
    tx_wr       = 1'b0;
    res         = '0;

    unique case (req_q.action)
      ACT_LINE: begin
        if (req_q.line_errors != '0) begin
          err_d = 1'b1;
        end else if (req_q.rx_ready) begin
          if (rx_full) begin
            err_d = 1'b1;
          end else begin
            rx_push   = 1'b1;
            rx_head_d = ptr_inc(rx_head_q);
          end
        end
        if (req_q.tx_empty && tx_en_q) begin
          if (tx_ring_empty) begin
            tx_en_d = 1'b0;
          end else begin
            tx_pop       = 1'b1;
            tx_tail_d    = ptr_inc(tx_tail_q);
            res.tx_valid = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (!rx_empty) begin
          rx_pop       = 1'b1;
          rx_tail_d    = ptr_inc(rx_tail_q);
          res.rx_valid = 1'b1;
        end
      end
      ACT_WRITE: begin
        // A burst is refused up front when it is empty or larger than the free space.
        if (opening && ((req_q.burst_len == '0) ||
                        (BW'(req_q.burst_len) > BW'(tx_free)))) begin
          rej_now = 1'b1;
        end
        if (!rej_now) begin
          res.accepted = 1'b1;
          // Bytes beyond the free space would overwrite unsent data and are dropped.
          if (burst_off_q < tx_free) begin
            tx_wr   = 1'b1;
            off_new = burst_off_q + CW'(1);
          end
        end
        if (req_q.burst_last) begin
          if (!rej_now) begin
            tx_head_d = ptr_add(tx_head_q, off_new);
            tx_en_d   = 1'b1;
          end
          burst_off_d = '0;
          burst_rej_d = 1'b0;
        end else begin
          burst_off_d = off_new;
          burst_rej_d = rej_now;
        end
      end
      ACT_TAKE_ERR: begin
        res.error_taken = err_q;
        if (err_q) begin
          rx_tail_d = rx_head_q;
        end
        err_d = 1'b0;
      end
      ACT_IDLE_QUERY: begin
        res.idle = tx_ring_empty && req_q.tx_complete;
      end
      default: begin
      end
    endcase

    res.tx_irq_enable = tx_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      burst_off_q <= '0;
      burst_rej_q <= 1'b0;
      err_q       <= 1'b0;
      tx_en_q     <= 1'b0;
    end else if (cmd_i.execute) begin
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      burst_off_q <= burst_off_d;
      burst_rej_q <= burst_rej_d;
      err_q       <= err_d;
      tx_en_q     <= tx_en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((cmd_i.execute && !status_o.need_read) || cmd_i.load_byte) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rsp_q <= res;
    end else if (cmd_i.load_byte) begin
      if (rsp_q.rx_valid) begin
        rsp_q.rx_byte <= rx_rdata;
      end
      if (rsp_q.tx_valid) begin
        rsp_q.tx_byte <= tx_rdata;
      end
    end
  end

  urbc_ram #(
    .Width (ByteW),
    .Depth (DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && rx_push),
    .waddr_i (slot(rx_head_q)),
    .wdata_i (req_q.data_byte),
    .re_i    (cmd_i.execute && rx_pop),
    .raddr_i (slot(rx_tail_q)),
    .rdata_o (rx_rdata)
  );

  urbc_ram #(
    .Width (ByteW),
    .Depth (DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && tx_wr),
    .waddr_i (tx_waddr),
    .wdata_i (req_q.data_byte),
    .re_i    (cmd_i.execute && tx_pop),
    .raddr_i (slot(tx_tail_q)),
    .rdata_o (tx_rdata)
  );

  assign status_o.out_busy  = rsp_valid_q && !rsp_ready_i;
  assign status_o.need_read = rx_pop || tx_pop;
  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_o              = rsp_q;

endmodule

// ----- sim/tb_uart_ring_buffer_channel_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the UART ring buffer channel unit with its own ring predictor.
module tb_uart_ring_buffer_channel_unit;
  import urbc_pkg::*;

  localparam int unsigned RING_DEPTH  = 512;
  localparam int unsigned PTR_SPAN    = 2 * RING_DEPTH;  // pointers count modulo twice the depth
  localparam int unsigned CLK_HALF_NS = 2;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned IDLE_PCT    = 13;
  // Window of cycles in which neither side idles, so back-to-back traffic is seen too.
  localparam int unsigned CALM_FIRST  = 1000;
  localparam int unsigned CALM_LAST   = 2500;
  // Tail of idle cycles that covers any straggler after the last result.
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned MAX_BURST_LEN = (1 << BurstLenW) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  urbc_req_if req_if ();
  urbc_rsp_if rsp_if ();

  // The request payload and both handshake controls are held in testbench registers that
  // start at known values, so the block never sees an unknown input.
  req_t req_drv   = '0;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;

  assign req_if.valid       = req_valid;
  assign req_if.action      = req_drv.action;
  assign req_if.rx_ready    = req_drv.rx_ready;
  assign req_if.line_errors = req_drv.line_errors;
  assign req_if.tx_empty    = req_drv.tx_empty;
  assign req_if.tx_complete = req_drv.tx_complete;
  assign req_if.data_byte   = req_drv.data_byte;
  assign req_if.burst_len   = req_drv.burst_len;
  assign req_if.burst_last  = req_drv.burst_last;
  assign rsp_if.ready       = rsp_ready;

  uart_ring_buffer_channel_unit #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Requests waiting to be driven, and the results that accepted requests must produce,
  // oldest first.
  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];

  // Predictor state: both rings, their pointers, the open burst, the sticky error flag and
  // the transmit interrupt enable, all as they stand after the last accepted request.
  logic [ByteW-1:0] rx_ring [RING_DEPTH];
  logic [ByteW-1:0] tx_ring [RING_DEPTH];
  int unsigned rx_wr_ptr = 0;
  int unsigned rx_rd_ptr = 0;
  int unsigned tx_wr_ptr = 0;
  int unsigned tx_rd_ptr = 0;
  int unsigned staged_bytes = 0;
  bit          burst_refused = 1'b0;
  bit          line_err_sticky = 1'b0;
  bit          tx_irq_on = 1'b0;

  int unsigned cycle_cnt   = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_results   = 0;
  int unsigned n_errors    = 0;
  int unsigned n_tx_sent   = 0;
  int unsigned n_rx_popped = 0;
  int unsigned n_refused   = 0;
  int unsigned n_rx_overflow = 0;
  int unsigned n_overlong_drops = 0;
  int unsigned n_err_taken = 0;

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  function automatic int unsigned ring_fill(input int unsigned head, input int unsigned tail);
    return (head + PTR_SPAN - tail) % PTR_SPAN;
  endfunction

  // Works out the result of one accepted request and advances the predictor state.
  task automatic predict_response(input req_t r);
    rsp_t        exp_rsp;
    int unsigned room;
    int unsigned blen;
    exp_rsp = '0;
    blen = 32'(r.burst_len);
    case (r.action)
      ACT_LINE: begin
        // Line errors take priority over a received byte; a full receive ring drops the
        // byte and raises the error instead.
        if (r.line_errors != '0) begin
          line_err_sticky = 1'b1;
        end else if (r.rx_ready) begin
          if (ring_fill(rx_wr_ptr, rx_rd_ptr) >= RING_DEPTH) begin
            line_err_sticky = 1'b1;
            n_rx_overflow++;
          end else begin
            rx_ring[rx_wr_ptr % RING_DEPTH] = r.data_byte;
            rx_wr_ptr = (rx_wr_ptr + 1) % PTR_SPAN;
          end
        end
        if (r.tx_empty && tx_irq_on) begin
          if (tx_rd_ptr == tx_wr_ptr) begin
            tx_irq_on = 1'b0;
          end else begin
            exp_rsp.tx_valid = 1'b1;
            exp_rsp.tx_byte  = tx_ring[tx_rd_ptr % RING_DEPTH];
            tx_rd_ptr = (tx_rd_ptr + 1) % PTR_SPAN;
            n_tx_sent++;
          end
        end
      end
      ACT_READ: begin
        if (rx_rd_ptr != rx_wr_ptr) begin
          exp_rsp.rx_valid = 1'b1;
          exp_rsp.rx_byte  = rx_ring[rx_rd_ptr % RING_DEPTH];
          rx_rd_ptr = (rx_rd_ptr + 1) % PTR_SPAN;
          n_rx_popped++;
        end
      end
      ACT_WRITE: begin
        room = RING_DEPTH - ring_fill(tx_wr_ptr, tx_rd_ptr);
        // The first byte of a burst decides whether the whole burst fits.
        if (staged_bytes == 0 && !burst_refused) begin
          if (blen == 0 || blen > room) begin
            burst_refused = 1'b1;
            n_refused++;
          end
        end
        if (!burst_refused) begin
          exp_rsp.accepted = 1'b1;
          if (staged_bytes < room) begin
            tx_ring[((tx_wr_ptr + staged_bytes) % PTR_SPAN) % RING_DEPTH] = r.data_byte;
            staged_bytes++;
          end else begin
            n_overlong_drops++;
          end
        end
        if (r.burst_last) begin
          if (!burst_refused) begin
            tx_wr_ptr = (tx_wr_ptr + staged_bytes) % PTR_SPAN;
            tx_irq_on = 1'b1;
          end
          staged_bytes  = 0;
          burst_refused = 1'b0;
        end
      end
      ACT_TAKE_ERR: begin
        exp_rsp.error_taken = line_err_sticky;
        if (line_err_sticky) begin
          rx_rd_ptr = rx_wr_ptr;
          n_err_taken++;
        end
        line_err_sticky = 1'b0;
      end
      ACT_IDLE_QUERY: begin
        exp_rsp.idle = (tx_wr_ptr == tx_rd_ptr) && r.tx_complete;
      end
      default: begin
        // Unused action codes leave everything as it is.
      end
    endcase
    exp_rsp.tx_irq_enable = tx_irq_on;
    expected_rsp_q.push_back(exp_rsp);
  endtask

  function automatic string fmt_rsp(input rsp_t v);
    return $sformatf("rx %b/%h tx %b/%h acc %b err %b idle %b en %b", v.rx_valid, v.rx_byte,
                     v.tx_valid, v.tx_byte, v.accepted, v.error_taken, v.idle, v.tx_irq_enable);
  endfunction

  // Compares one result from the block, field by field, with the oldest expectation.
  task automatic check_response(input rsp_t got);
    rsp_t  want;
    string diffs;
    n_results++;
    if (expected_rsp_q.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("ERROR: result %0d arrived with nothing expected: %s", n_results, fmt_rsp(got));
      end
      return;
    end
    want  = expected_rsp_q.pop_front();
    diffs = "";
    if (got.rx_valid !== want.rx_valid) diffs = {diffs, " rx_valid"};
    if (got.rx_byte !== want.rx_byte) diffs = {diffs, " rx_byte"};
    if (got.tx_valid !== want.tx_valid) diffs = {diffs, " tx_valid"};
    if (got.tx_byte !== want.tx_byte) diffs = {diffs, " tx_byte"};
    if (got.accepted !== want.accepted) diffs = {diffs, " accepted"};
    if (got.error_taken !== want.error_taken) diffs = {diffs, " error_taken"};
    if (got.idle !== want.idle) diffs = {diffs, " idle"};
    if (got.tx_irq_enable !== want.tx_irq_enable) diffs = {diffs, " tx_irq_enable"};
    if (diffs != "") begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("ERROR: result %0d differs in%s", n_results, diffs);
        $display("  expected %s", fmt_rsp(want));
        $display("  actual   %s", fmt_rsp(got));
      end
    end
  endtask

  // Every field random; callers then set the fields that matter for the action, so the
  // fields the block must ignore still carry noise.
  function automatic req_t random_req();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic bit take_idle_cycle();
    if (cycle_cnt >= CALM_FIRST && cycle_cnt < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic add_line(input bit rx_rdy, input logic [ErrW-1:0] errs, input bit txe,
                          input logic [ByteW-1:0] b);
    req_t r;
    r = random_req();
    r.action      = ACT_LINE;
    r.rx_ready    = rx_rdy;
    r.line_errors = errs;
    r.tx_empty    = txe;
    r.data_byte   = b;
    pending_req_q.push_back(r);
  endtask

  task automatic add_op(input logic [ActionW-1:0] act, input bit tc);
    req_t r;
    r = random_req();
    r.action      = act;
    r.tx_complete = tc;
    pending_req_q.push_back(r);
  endtask

  // A host write burst of nbytes bytes that announces len bytes. Later bytes sometimes carry
  // a stray length, and line events that drain the transmitter may fall inside the burst.
  task automatic add_burst(input int unsigned len, input int unsigned nbytes,
                           input int unsigned mix_pct);
    req_t r;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 99) < mix_pct) begin
        add_line(1'($urandom_range(0, 1)), '0, 1'b1, 8'($urandom));
      end
      r = random_req();
      r.action = ACT_WRITE;
      if (i == 0 || $urandom_range(0, 3) != 0) r.burst_len = BurstLenW'(len);
      r.burst_last = (i == nbytes - 1);
      pending_req_q.push_back(r);
    end
  endtask

  // Mixed traffic that keeps both rings shallow: short bursts, line events, reads, error
  // takes, idle queries and the unused action codes.
  task automatic add_mixed(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [ErrW-1:0] errs;
    stop_at = pending_req_q.size() + count;
    while (pending_req_q.size() < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        len = $urandom_range(1, 4);
        case ($urandom_range(0, 19))
          0: add_burst(0, $urandom_range(1, 3), 10);
          1: add_burst($urandom_range(RING_DEPTH + 1, MAX_BURST_LEN), $urandom_range(1, 3), 10);
          2: add_burst(len, $urandom_range(1, 7), 20);
          default: add_burst(len, len, 15);
        endcase
      end else if (pick < 63) begin
        errs = ($urandom_range(0, 99) < 8) ? ErrW'($urandom_range(1, 15)) : '0;
        add_line(1'($urandom_range(0, 1)), errs, $urandom_range(0, 99) < 80, 8'($urandom));
      end else if (pick < 76) begin
        add_op(ACT_READ, 1'($urandom_range(0, 1)));
      end else if (pick < 83) begin
        add_op(ACT_TAKE_ERR, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        add_op(ACT_IDLE_QUERY, 1'($urandom_range(0, 1)));
      end else begin
        add_op(ActionW'($urandom_range(5, 7)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Driver: presents queued requests, holds each until the block takes it, and feeds every
  // accepted request to the predictor. Random idle cycles drop valid between requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_drv   <= '0;
    end else begin
      if (req_valid && req_if.ready) begin
        predict_response(req_drv);
        n_accepted++;
      end
      if (!req_valid || req_if.ready) begin
        if (pending_req_q.size() != 0 && !take_idle_cycle()) begin
          req_drv   <= pending_req_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_drv   <= random_req();
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes each result on a handshake and checks it; ready stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        check_response({rsp_if.rx_valid, rsp_if.rx_byte, rsp_if.tx_valid, rsp_if.tx_byte,
                        rsp_if.accepted, rsp_if.error_taken, rsp_if.idle,
                        rsp_if.tx_irq_enable});
      end
      rsp_ready <= !take_idle_cycle();
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles with %0d requests queued, %0d results due",
               cycle_cnt, pending_req_q.size(), expected_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned stop_at;
    int unsigned len;

    // Directed opening. An idle query on an empty transmit ring, with and without the
    // shifter done, then a read of an empty receive ring and a take with the flag clear.
    add_op(ACT_IDLE_QUERY, 1'b1);
    add_op(ACT_IDLE_QUERY, 1'b0);
    add_op(ACT_READ, 1'b0);
    add_op(ACT_TAKE_ERR, 1'b0);
    // Two clean bytes at the byte extremes; the enable is still off, so the empty
    // transmitter gets nothing. Then line errors, which win over the received byte.
    add_line(1'b1, 4'h0, 1'b0, 8'h00);
    add_line(1'b1, 4'h0, 1'b1, 8'hFF);
    add_line(1'b1, 4'hF, 1'b0, 8'h5A);
    add_op(ACT_READ, 1'b0);
    add_op(ACT_READ, 1'b0);
    add_op(ACT_READ, 1'b0);
    // Taking the set error flushes the byte that arrived after it.
    add_line(1'b1, 4'h0, 1'b0, 8'h3C);
    add_op(ACT_TAKE_ERR, 1'b1);
    add_op(ACT_READ, 1'b1);
    // A burst of length zero and one longer than the ring are both refused.
    add_burst(0, 1, 0);
    add_burst(MAX_BURST_LEN, 1, 0);
    // An accepted burst, drained by line events until the enable drops.
    add_burst(2, 2, 0);
    add_op(ACT_IDLE_QUERY, 1'b1);
    repeat (3) add_line(1'b0, 4'h0, 1'b1, 8'($urandom));
    add_op(ACT_IDLE_QUERY, 1'b1);
    // A burst that sends more bytes than it announced, and the unused action codes.
    add_burst(1, 2, 0);
    add_op(ActionW'(5), 1'b1);
    add_op(ActionW'(6), 1'b0);
    add_op(ActionW'(7), 1'b1);

    add_mixed(120);

    // Fill the transmit ring with back-to-back bursts and no draining. Once it is nearly
    // full, short announced lengths followed by many bytes overrun the free space, and
    // long announced lengths are refused.
    stop_at = pending_req_q.size() + 540;
    while (pending_req_q.size() < stop_at) begin
      if (pending_req_q.size() + 200 < stop_at) begin
        len = $urandom_range(16, 48);
        add_burst(len, len, 0);
      end else begin
        add_burst($urandom_range(1, 4), $urandom_range(20, 40), 0);
      end
    end

    // Flood the receive ring past full while the line also drains the transmit ring.
    repeat (540) begin
      add_line(1'b1, ($urandom_range(0, 99) < 2) ? ErrW'($urandom_range(1, 15)) : '0,
               $urandom_range(0, 99) < 85, 8'($urandom));
    end
    repeat (10) add_op(ACT_READ, 1'($urandom_range(0, 1)));
    add_op(ACT_TAKE_ERR, 1'($urandom_range(0, 1)));
    add_op(ACT_READ, 1'($urandom_range(0, 1)));

    add_mixed(80);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (expected_rsp_q.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", expected_rsp_q.size());
      n_errors += expected_rsp_q.size();
    end
    $display("Run covered %0d requests and %0d results: %0d bytes sent, %0d bytes read, %0d bursts refused.",
             n_accepted, n_results, n_tx_sent, n_rx_popped, n_refused);
    $display("Receive overflows %0d, overlong burst drops %0d, errors taken while set %0d, mismatches %0d.",
             n_rx_overflow, n_overlong_drops, n_err_taken, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/urbc_pkg.sv
src/urbc_req_if.sv
src/urbc_rsp_if.sv
src/urbc_ram.sv
src/urbc_ctrl.sv
src/urbc_datapath.sv
src/uart_ring_buffer_channel_unit.sv
sim/tb_uart_ring_buffer_channel_unit.sv
